// ----- src/lhs_pkg.sv -----
package lhs_pkg;

   localparam int unsigned EDGE_TABLE_LEN = 10;
   localparam int unsigned PCT_MAX        = 100;
   localparam int unsigned PCT_ROUND      = 99;
   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_REPORT = 2'd2;

   localparam logic [31:0] EDGE_TABLE [EDGE_TABLE_LEN] = '{
      32'd100, 32'd250, 32'd500, 32'd1000, 32'd2000,
      32'd4000, 32'd8000, 32'd16000, 32'd32000, 32'd64000
   };

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] latency_us;
      logic [7:0]  pct;
   } req_type;

   typedef struct packed {
      logic [31:0] sample_total;
      logic [31:0] min_us;
      logic [31:0] max_us;
      logic [31:0] mean_us;
      logic [31:0] percentile_us;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_CLEAR,
      OP_REPORT,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] latency_us;
      logic [7:0]  pct;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MEAN,
      B_WALK,
      B_OUT
   } back_state_type;

   // Upper edge of bucket i; the last bucket and anything past the table is open.
   function automatic logic [31:0] bucket_edge(int unsigned i, int unsigned nb);
      logic [31:0] edge_val;
      edge_val = '1;
      if (i < EDGE_TABLE_LEN && i + 1 < nb) begin
         edge_val = EDGE_TABLE[i[3:0]];
      end
      return edge_val;
   endfunction

endpackage

// ----- src/lhs_front.sv -----
module lhs_front import lhs_pkg::*; #(
   parameter int unsigned NUM_BUCKETS = 11,
   parameter int unsigned IDX_W       = $clog2(NUM_BUCKETS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             cmd_valid,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] cmd_idx,
   input  logic             cmd_pop
);

   cmd_type          q_cmd_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] q_idx_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_type          dec_cmd;
   logic [IDX_W-1:0] dec_idx;
   logic             push;

   // decode mode and pick the bucket for the sample
   always_comb begin
      dec_cmd.latency_us = req_data.latency_us;
      dec_cmd.pct        = req_data.pct;
      case (req_data.mode)
         MODE_ADD:    dec_cmd.op = OP_ADD;
         MODE_CLEAR:  dec_cmd.op = OP_CLEAR;
         MODE_REPORT: dec_cmd.op = OP_REPORT;
         default:     dec_cmd.op = OP_NOP;
      endcase
      dec_idx = IDX_W'(NUM_BUCKETS - 1);
      for (int j = NUM_BUCKETS - 1; j >= 0; j--) begin
         if (req_data.latency_us <= bucket_edge(j, NUM_BUCKETS)) begin
            dec_idx = IDX_W'(j);
         end
      end
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_cmd_ff[rd_ptr_ff];
   assign cmd_idx   = q_idx_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, cmd_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (cmd_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff] <= dec_cmd;
         q_idx_ff[wr_ptr_ff] <= dec_idx;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

// ----- src/lhs_div.sv -----
module lhs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] dvd_ff;
   logic [31:0] rem_ff, dsr_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] shifted, diff;

   // restoring divide, one quotient bit per cycle
   assign shifted  = {rem_ff, dvd_ff[63]};
   assign diff     = shifted - {1'b0, dsr_ff};
   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_ff <= diff[31:0];
            dvd_ff <= {dvd_ff[62:0], 1'b1};
         end else begin
            rem_ff <= shifted[31:0];
            dvd_ff <= {dvd_ff[62:0], 1'b0};
         end
      end
   end

endmodule

// ----- src/lhs_back.sv -----
module lhs_back import lhs_pkg::*; #(
   parameter int unsigned NUM_BUCKETS = 11,
   parameter int unsigned IDX_W       = $clog2(NUM_BUCKETS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] cmd_idx,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   // running bucket total scaled by 100: NUM_BUCKETS x 32-bit x 100 fits
   localparam int unsigned ACC_W = 39 + IDX_W;

   back_state_type    state_ff, state_in;
   logic [31:0]       count_ff, count_in;
   logic [63:0]       sum_ff, sum_in;
   logic [31:0]       min_ff, min_in;
   logic [31:0]       max_ff, max_in;
   logic [31:0]       bucket_ff [NUM_BUCKETS];
   logic [7:0]        pct_ff, pct_in;
   logic [39:0]       prod_ff, prod_in;
   logic [31:0]       mean_ff, mean_in;
   logic [31:0]       pres_ff, pres_in;
   logic [IDX_W-1:0]  walk_ff, walk_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  rd_addr;
   logic [31:0]       rd_data;
   logic [38:0]       rd_x100;
   logic [ACC_W-1:0]  acc_sum;
   logic              bkt_inc, bkt_clr;
   logic              div_start, div_busy, div_done;
   logic [63:0]       div_dividend, div_q;
   logic [31:0]       div_divisor;
   logic              pct_ok;

   lhs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // single read port into the bucket file: walk index or the add's bucket
   assign rd_addr = (state_ff == B_WALK) ? walk_ff : cmd_idx;
   assign rd_data = bucket_ff[rd_addr];
   // 100 * total >= count * pct is the same test as total >= ceil(count * pct / 100)
   assign rd_x100 = {1'b0, rd_data, 6'd0} + {2'b0, rd_data, 5'd0} + {5'b0, rd_data, 2'd0};
   assign acc_sum = acc_ff + ACC_W'(rd_x100);
   assign pct_ok  = (pct_ff != 8'd0) && (pct_ff <= 8'(PCT_MAX));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      pct_in       = pct_ff;
      prod_in      = prod_ff;
      mean_in      = mean_ff;
      pres_in      = pres_ff;
      walk_in      = walk_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      bkt_inc      = 1'b0;
      bkt_clr      = 1'b0;
      div_start    = 1'b0;
      div_dividend = sum_ff;
      div_divisor  = count_ff;

      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_ADD: begin
                     count_in = count_ff + 32'd1;
                     sum_in   = sum_ff + 64'(cmd.latency_us);
                     if (cmd.latency_us > max_ff) begin
                        max_in = cmd.latency_us;
                     end
                     if (cmd.latency_us < min_ff) begin
                        min_in = cmd.latency_us;
                     end
                     bkt_inc = 1'b1;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     sum_in   = '0;
                     min_in   = '1;
                     max_in   = '0;
                     bkt_clr  = 1'b1;
                  end
                  OP_REPORT: begin
                     pct_in    = cmd.pct;
                     prod_in   = 40'(count_ff) * 40'(cmd.pct);
                     div_start = 1'b1;
                     state_in  = B_MEAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_MEAN: begin
            if (div_done) begin
               mean_in  = div_q[31:0];
               walk_in  = '0;
               acc_in   = '0;
               state_in = B_WALK;
            end
         end
         B_WALK: begin
            acc_in = acc_sum;
            if (acc_sum >= ACC_W'(prod_ff)) begin
               pres_in  = bucket_edge(32'(walk_ff), NUM_BUCKETS);
               state_in = B_OUT;
            end else if (walk_ff == IDX_W'(NUM_BUCKETS - 1)) begin
               pres_in  = '1;
               state_in = B_OUT;
            end else begin
               walk_in = walk_ff + IDX_W'(1);
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.sample_total  = count_ff;
               rsp_in.min_us        = min_ff;
               rsp_in.max_us        = max_ff;
               rsp_in.mean_us       = (count_ff == '0) ? '0 : mean_ff;
               rsp_in.percentile_us = (count_ff == '0 || !pct_ok) ? '0 : pres_ff;
               state_in             = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pct_ff    <= pct_in;
      prod_ff   <= prod_in;
      mean_ff   <= mean_in;
      pres_ff   <= pres_in;
      walk_ff   <= walk_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || bkt_clr) begin
         for (int j = 0; j < NUM_BUCKETS; j++) begin
            bucket_ff[j] <= '0;
         end
      end else if (bkt_inc) begin
         bucket_ff[cmd_idx] <= rd_data + 32'd1;
      end
   end

`ifndef SYNTHESIS
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_WALK |-> walk_ff <= IDX_W'(NUM_BUCKETS - 1))
      else $error("bucket walk out of range");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_OUT && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("report result not loaded");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != B_IDLE |-> !cmd_pop)
      else $error("queue popped during report");
`endif

endmodule

// ----- src/latency_histogram_stats_top.sv -----
// Latency histogram with percentile.
// req_ channel: valid/ready transactions carrying mode, latency_us and pct.
//   mode add folds the sample into count, 64-bit sum, min, max and one of
//   NUM_BUCKETS buckets; clear empties everything; report yields one rsp_
//   transaction; the unused mode code is dropped.
// Transactions enter a four-entry command queue; req_ready drops only when it
//   is full. The executing side takes one add or clear per cycle while no report
//   holds it, so a stream of samples sustains one transaction per cycle; an
//   accepted transaction is registered in the queue before the statistics update.
// A report holds the executing side while the radix-2 divider forms the mean,
//   then walks the buckets one per cycle comparing 100 * running total with
//   count * pct (1 to NUM_BUCKETS buckets walked), then loads the output
//   register, which raises rsp_valid.
//   Samples behind a report wait in the queue until it finishes.
// The result sits in an output register; while rsp_ready is low, further
//   adds still run, and a second report waits at its end for the register.
// Reset (synchronous, active high) empties the queue and the statistics:
//   count, sum, max and buckets zero, min all ones.
module latency_histogram_stats_top import lhs_pkg::*; #(
   parameter int unsigned NUM_BUCKETS = 11
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(NUM_BUCKETS);

   logic             cmd_valid;
   cmd_type          cmd;
   logic [IDX_W-1:0] cmd_idx;
   logic             cmd_pop;

   // front: decode and bucket classification, then the command queue
   lhs_front #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .IDX_W       (IDX_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_idx   (cmd_idx),
      .cmd_pop   (cmd_pop)
   );

   // back: statistics state, report sequencer and output register
   lhs_back #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .IDX_W       (IDX_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_idx   (cmd_idx),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/latency_histogram_stats_top_test.sv -----
// Self-checking bench for the latency histogram block.
module latency_histogram_stats_top_test import lhs_pkg::*; ();

   localparam int unsigned NUM_BUCKETS  = 11;
   localparam int          QUIET_LIMIT  = 5000;  // cycles with no transaction at all
   localparam int          TAIL_CYCLES  = 200;   // outlasts one report
   localparam int          RANDOM_ITEMS = 420;   // per pacing phase, four phases
   localparam int          PRINT_LIMIT  = 40;

   // mode code with no meaning; the block must drop it
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // fixed bucket tops; the last bucket is open-ended
   localparam logic [31:0] BUCKET_TOPS [10] = '{
      32'd100, 32'd250, 32'd500, 32'd1000, 32'd2000,
      32'd4000, 32'd8000, 32'd16000, 32'd32000, 32'd64000
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // transactions waiting to be driven, and reports still owed by the block
   req_type pending_reqs[$];
   rsp_type expected_reports[$];

   // pacing knobs, percent of cycles
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;

   // shadow statistics
   logic [31:0] n_samples;
   logic [63:0] sum_us;
   logic [31:0] lo_us;
   logic [31:0] hi_us;
   logic [31:0] bucket_hits [NUM_BUCKETS];

   int mismatches    = 0;
   int reqs_accepted = 0;
   int reports_seen  = 0;
   int adds_seen     = 0;
   int clears_seen   = 0;
   int bad_pct_seen  = 0;
   int quiet_cycles  = 0;

   latency_histogram_stats_top #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Histogram predictor
   // ---------------------------------------------------------------------
   function automatic logic [31:0] bucket_limit(int unsigned i);
      if (i < 10 && i + 1 < NUM_BUCKETS) begin
         return BUCKET_TOPS[i[3:0]];
      end
      return '1;
   endfunction

   task automatic empty_stats();
      n_samples = '0;
      sum_us    = '0;
      lo_us     = '1;
      hi_us     = '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         bucket_hits[i] = '0;
      end
   endtask

   // Apply one accepted transaction to the shadow state; a report also
   // queues the result the block owes us.
   task automatic fold_request(req_type t);
      rsp_type     want;
      logic [63:0] goal;
      logic [63:0] running;
      logic        placed;
      case (t.mode)
         MODE_ADD: begin
            adds_seen++;
            n_samples = n_samples + 32'd1;
            sum_us    = sum_us + {32'd0, t.latency_us};
            if (t.latency_us > hi_us) begin
               hi_us = t.latency_us;
            end
            if (t.latency_us < lo_us) begin
               lo_us = t.latency_us;
            end
            placed = 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
               if (!placed && t.latency_us <= bucket_limit(i)) begin
                  bucket_hits[i] = bucket_hits[i] + 32'd1;
                  placed = 1'b1;
               end
            end
         end
         MODE_CLEAR: begin
            clears_seen++;
            empty_stats();
         end
         MODE_REPORT: begin
            reports_seen++;
            want.sample_total = n_samples;
            want.min_us       = lo_us;
            want.max_us       = hi_us;
            want.mean_us      = '0;
            want.percentile_us = '0;
            if (n_samples != 0) begin
               want.mean_us = 32'(sum_us / {32'd0, n_samples});
            end
            if (t.pct == 0 || t.pct > PCT_MAX) begin
               bad_pct_seen++;
            end
            if (n_samples != 0 && t.pct != 0 && t.pct <= PCT_MAX) begin
               // ceiling of count * pct / 100, then walk buckets to reach it
               goal    = ({32'd0, n_samples} * {56'd0, t.pct} + 64'(PCT_ROUND))
                         / 64'(PCT_MAX);
               running = '0;
               placed  = 1'b0;
               want.percentile_us = '1;  // target never reached
               for (int i = 0; i < NUM_BUCKETS; i++) begin
                  if (!placed) begin
                     running = running + {32'd0, bucket_hits[i]};
                     if (running >= goal) begin
                        want.percentile_us = bucket_limit(i);
                        placed = 1'b1;
                     end
                  end
               end
            end
            expected_reports.push_back(want);
         end
         default: begin
            // unused code: no state change, no result
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Mismatch reporting
   // ---------------------------------------------------------------------
   task automatic note_failure(string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("MISMATCH @%0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         note_failure($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: pops pending transactions, holds valid and payload until
   // accepted, feeds the predictor at the accepting edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            fold_request(req_data);
            reqs_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random backpressure, compares each report transaction with
   // the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               note_failure($sformatf("report with none pending, total %h",
                                      rsp_data.sample_total));
            end else begin
               want = expected_reports.pop_front();
               check_field("sample_total", rsp_data.sample_total, want.sample_total);
               check_field("min_us", rsp_data.min_us, want.min_us);
               check_field("max_us", rsp_data.max_us, want.max_us);
               check_field("mean_us", rsp_data.mean_us, want.mean_us);
               check_field("percentile_us", rsp_data.percentile_us, want.percentile_us);
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: a long run of cycles with no transaction on either side
   // means the block hung or lost a report.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d reports outstanding",
                  QUIET_LIMIT, expected_reports.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic queue_req(logic [1:0] m, logic [31:0] s, logic [7:0] p);
      req_type t;
      t.mode       = m;
      t.latency_us = s;
      t.pct        = p;
      pending_reqs.push_back(t);
   endtask

   // Sample aimed at the buckets: inside a bucket, right on or past a top,
   // full 32-bit range, or tiny.
   function automatic logic [31:0] pick_latency();
      int unsigned b;
      int unsigned k;
      logic [31:0] lo;
      k = $urandom_range(9);
      b = $urandom_range(NUM_BUCKETS - 1);
      lo = (b == 0) ? 32'd0 : bucket_limit(b - 1) + 32'd1;
      if (k <= 5) begin
         return $urandom_range(bucket_limit(b), lo);
      end else if (k == 6) begin
         return bucket_limit(b) + 32'($urandom_range(1));
      end else if (k <= 8) begin
         return $urandom;
      end
      return $urandom_range(10);
   endfunction

   function automatic logic [7:0] pick_pct();
      int unsigned k;
      k = $urandom_range(9);
      if (k <= 6) begin
         return 8'($urandom_range(100, 1));
      end else if (k == 7) begin
         case ($urandom_range(3))
            0: return 8'd1;
            1: return 8'd100;
            2: return 8'd99;
            default: return 8'd50;
         endcase
      end else if (k == 8) begin
         return 8'($urandom_range(255));
      end
      return $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 101));
   endfunction

   // Mostly samples with the odd report, occasional clear; unused-mode
   // noise does not count toward the phase size.
   task automatic queue_random_phase(int items);
      int made;
      int unsigned r;
      made = 0;
      while (made < items) begin
         r = $urandom_range(99);
         if (r < 80) begin
            queue_req(MODE_ADD, pick_latency(), 8'($urandom));
            made++;
         end else if (r < 92) begin
            queue_req(MODE_REPORT, $urandom, pick_pct());
            made++;
         end else if (r < 94) begin
            queue_req(MODE_CLEAR, $urandom, 8'($urandom));
            made++;
         end else begin
            queue_req(MODE_UNUSED, $urandom, 8'($urandom));
         end
      end
   endtask

   // Let everything queued go through, then hold off the sender until
   // every report owed has come back.
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_reports.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      empty_stats();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corners, no idling: empty store, bucket tops and their
      // neighbors, extreme samples, every percentile edge, unused mode,
      // report straight after clear.
      queue_req(MODE_REPORT, 32'd0, 8'd50);
      queue_req(MODE_REPORT, 32'd0, 8'd0);
      queue_req(MODE_ADD, 32'd0, 8'd0);
      queue_req(MODE_ADD, 32'd100, 8'd0);
      queue_req(MODE_ADD, 32'd101, 8'd0);
      queue_req(MODE_ADD, 32'd250, 8'd0);
      queue_req(MODE_ADD, 32'd64000, 8'd0);
      queue_req(MODE_ADD, 32'd64001, 8'd0);
      queue_req(MODE_ADD, 32'hFFFF_FFFF, 8'hFF);
      queue_req(MODE_ADD, 32'd1000, 8'd0);
      queue_req(MODE_REPORT, 32'd0, 8'd1);
      queue_req(MODE_REPORT, 32'd0, 8'd50);
      queue_req(MODE_REPORT, 32'd0, 8'd100);
      queue_req(MODE_REPORT, 32'd0, 8'd101);
      queue_req(MODE_REPORT, 32'hFFFF_FFFF, 8'd255);
      queue_req(MODE_UNUSED, 32'hFFFF_FFFF, 8'hFF);
      queue_req(MODE_REPORT, 32'd0, 8'd99);
      queue_req(MODE_CLEAR, 32'd0, 8'd0);
      queue_req(MODE_REPORT, 32'd0, 8'd100);
      queue_req(MODE_ADD, 32'd7, 8'd0);
      queue_req(MODE_REPORT, 32'd0, 8'd100);
      queue_req(MODE_REPORT, 32'd0, 8'd1);
      drain();

      // Pacing phases: free flow, sparse sender, heavy backpressure, both.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 86; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_gap_pct = 22; rsp_stall_pct = 22; end
         endcase
         queue_random_phase(RANDOM_ITEMS);
         drain();
      end

      // quiet tail so a stray extra report would still be caught
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_reports.size() != 0) begin
         note_failure($sformatf("%0d reports never arrived", expected_reports.size()));
      end

      $display("Run covered %0d transactions: %0d samples, %0d clears, %0d reports",
               reqs_accepted, adds_seen, clears_seen, reports_seen);
      $display("(%0d with pct out of range) under free flow, sparse sender, %s; %0d mismatches",
               bad_pct_seen, "heavy backpressure and mixed pacing", mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/lhs_pkg.sv
src/lhs_front.sv
src/lhs_div.sv
src/lhs_back.sv
src/latency_histogram_stats_top.sv
tb/sv/latency_histogram_stats_top_test.sv
